// ===== sv/pcd_pkg.sv =====
// Shared types and constants of the periodic crossing detector.
// No dependencies; imported by pcd_mem, periodic_crossing_detector_unit and the bench.
package pcd_pkg;

    localparam int DEF_MAX_PARTICLES = 4096;
    localparam int INDEX_W = 12;
    localparam int FRAME_W = 20;
    localparam int COORD_W = 32;
    localparam int SHIFT_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_AXES = 3;

    localparam logic [SHIFT_W:0] SHIFT_LIMIT = 17'd32767;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_RECIP_XX_XY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECIP_XZ_TX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECIP_YX_YY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECIP_YZ_TY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECIP_ZX_ZY = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECIP_ZZ_TZ = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIODIC_MASK = 3'd6;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // One table entry: seen flag and the stored reduced position, x in slot 0.
    typedef struct packed {
        logic                              seen;
        logic [NUM_AXES-1:0][COORD_W-1:0]  red;
    } t_entry;

endpackage

// ===== sv/pcd_mem.sv =====
// Single-port-write, single-port-read table of reduced positions and seen flags.
// Depends on pcd_pkg for the entry type.
module pcd_mem
    import pcd_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_PARTICLES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/periodic_crossing_detector_unit.sv =====
// Top level of the periodic crossing detector: pipeline, forwarding and record output.
// Depends on pcd_pkg and pcd_mem.
//
// Each accepted request is one particle sample. The unit maps its position to reduced
// cell coordinates, compares them with the coordinates stored for that particle and
// emits one crossing record for each periodic axis whose rounded shift is nonzero,
// in axis order, with rec_last on the final record of the sample. The pipeline has
// five register stages (input and table read, nine 32x32 products, row sums, reduced
// coordinates with the table write, per-axis shifts in the output stage) and accepts
// one sample per cycle, except while a pending record waits on i_ready and while a
// sample with several records is still in the output stage. A sample that causes two
// or three records holds the output stage until its last record is taken, so the
// input stalls until then. Same-index samples in flight are forwarded from the write
// stage, so back-to-back samples of one particle are handled at full rate. After
// reset the table is cleared, one entry per cycle; o_ready stays low until that pass
// ends, while configuration writes are taken at any time. Samples with an index not
// below MAX_PARTICLES pass through without records and without touching the table.
module periodic_crossing_detector_unit
    import pcd_pkg::*;
#(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Sample input channel.
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [INDEX_W-1:0]        i_particle_index,
    input  logic [FRAME_W-1:0]        i_frame_number,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    // Crossing record output channel.
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [INDEX_W-1:0]        o_rec_index,
    output logic [FRAME_W-1:0]        o_rec_frame,
    output logic [1:0]                o_rec_axis,
    output logic signed [SHIFT_W-1:0] o_rec_shift,
    output logic                      o_rec_last,
    // Configuration write channel.
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int IW = 21;
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_PARTICLES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PARTICLES - 1);
    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W = PROD_W + 3;
    localparam int QUO_W = SUM_W - 30;
    localparam int RED_W = QUO_W + 1;

    // Configuration registers: six coefficient and translation words and the periodic mask.
    logic [CFG_DATA_W-1:0] r_cfg [6];
    logic [NUM_AXES-1:0]   r_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_cfg[i] <= '0;
            end
            r_mask <= 3'd7;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RECIP_XX_XY, CFG_RECIP_XZ_TX, CFG_RECIP_YX_YY,
                CFG_RECIP_YZ_TY, CFG_RECIP_ZX_ZY, CFG_RECIP_ZZ_TZ: begin
                    r_cfg[i_cfg_index] <= i_cfg_data;
                end
                CFG_PERIODIC_MASK: begin
                    r_mask <= i_cfg_data[NUM_AXES-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clearing pass over the table after reset.
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Pipeline registers.
    logic                      r_s1_valid, r_s1_inr, r_s1_fwd;
    logic [INDEX_W-1:0]        r_s1_idx;
    logic [FRAME_W-1:0]        r_s1_frame;
    logic signed [COORD_W-1:0] r_s1_pos [NUM_AXES];
    t_entry                    r_s1_fwd_entry;

    logic                      r_s2_valid, r_s2_inr;
    logic [INDEX_W-1:0]        r_s2_idx;
    logic [FRAME_W-1:0]        r_s2_frame;
    logic signed [PROD_W-1:0]  r_s2_prod [NUM_AXES][NUM_AXES];
    t_entry                    r_s2_prev;

    logic                      r_s3_valid, r_s3_inr;
    logic [INDEX_W-1:0]        r_s3_idx;
    logic [FRAME_W-1:0]        r_s3_frame;
    logic signed [SUM_W-1:0]   r_s3_sum [NUM_AXES];
    t_entry                    r_s3_prev;

    logic                      r_s4_valid, r_s4_inr;
    logic [INDEX_W-1:0]        r_s4_idx;
    logic [FRAME_W-1:0]        r_s4_frame;
    logic [NUM_AXES-1:0][COORD_W-1:0] r_s4_red;
    t_entry                    r_s4_prev;

    logic [NUM_AXES-1:0]       r_s5_pend;
    logic [INDEX_W-1:0]        r_s5_idx;
    logic [FRAME_W-1:0]        r_s5_frame;
    logic signed [SHIFT_W-1:0] r_s5_shift [NUM_AXES];

    // Output stage: lowest pending axis goes out first.
    logic                en;
    logic                rec_last;
    logic [NUM_AXES-1:0] low_bit;

    always_comb begin
        low_bit = r_s5_pend & (~r_s5_pend + 1'b1);
        rec_last = (r_s5_pend & (r_s5_pend - 1'b1)) == '0;
        o_rec_axis = AXIS_X;
        if (low_bit[1]) begin
            o_rec_axis = AXIS_Y;
        end else if (low_bit[2]) begin
            o_rec_axis = AXIS_Z;
        end
    end

    assign o_valid = r_s5_pend != '0;
    assign o_rec_index = r_s5_idx;
    assign o_rec_frame = r_s5_frame;
    assign o_rec_shift = r_s5_shift[o_rec_axis];
    assign o_rec_last = rec_last;

    // The whole pipeline moves when the output stage is empty or empties this cycle.
    assign en = (r_s5_pend == '0) || (i_ready && rec_last);
    assign o_ready = en && !r_clr_busy;

    logic accept;
    assign accept = i_valid && o_ready;

    // Write stage: stage 4 stores its result as it moves on; younger samples snoop it.
    logic   wr_act;
    t_entry wr_entry;
    assign wr_act = r_s4_valid && r_s4_inr && en;
    assign wr_entry = '{seen: 1'b1, red: r_s4_red};

    function automatic t_entry snoop(input t_entry cur, input logic [INDEX_W-1:0] idx,
                                     input logic act, input logic [INDEX_W-1:0] widx,
                                     input t_entry wval);
        t_entry res;
        res = cur;
        if (act && idx == widx) begin
            res = wval;
        end
        return res;
    endfunction

    // Table.
    logic [IW-1:0] in_idx_w, wr_idx_w;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          mem_we;
    t_entry        mem_wdata, mem_rdata, s1_prev;

    assign in_idx_w = IW'(i_particle_index);
    assign wr_idx_w = IW'(r_s4_idx);
    assign rd_addr = in_idx_w[AW-1:0];
    assign mem_we = r_clr_busy || wr_act;
    assign wr_addr = r_clr_busy ? r_clr_addr : wr_idx_w[AW-1:0];
    assign mem_wdata = r_clr_busy ? t_entry'('0) : wr_entry;
    assign s1_prev = r_s1_fwd ? r_s1_fwd_entry : mem_rdata;

    pcd_mem #(
        .DEPTH (MAX_PARTICLES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wr_addr),
        .i_wdata (mem_wdata),
        .i_re    (en),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    // Stage arithmetic.
    logic signed [SUM_W-1:0]   n_sum [NUM_AXES];
    logic [NUM_AXES-1:0][COORD_W-1:0] n_red;
    logic signed [SHIFT_W-1:0] n_shift [NUM_AXES];
    logic [NUM_AXES-1:0]       n_pend;

    always_comb begin
        logic signed [QUO_W-1:0]   quo;
        logic signed [RED_W-1:0]   red_w;
        logic signed [COORD_W:0]   diff;
        logic [COORD_W:0]          mag;
        logic [COORD_W+1:0]        rnd;
        logic [SHIFT_W:0]          cnt;
        for (int r = 0; r < NUM_AXES; r++) begin
            n_sum[r] = SUM_W'(r_s2_prod[r][0]) + SUM_W'(r_s2_prod[r][1])
                     + SUM_W'(r_s2_prod[r][2]) + SUM_W'(64'sd536870912);
        end
        for (int r = 0; r < NUM_AXES; r++) begin
            quo = r_s3_sum[r][SUM_W-1:30];
            red_w = RED_W'(quo) + RED_W'(signed'(r_cfg[2*r+1][COORD_W-1:0]));
            if (red_w > RED_W'(64'sh7FFFFFFF)) begin
                n_red[r] = 32'h7FFF_FFFF;
            end else if (red_w < -RED_W'(64'sh80000000)) begin
                n_red[r] = 32'h8000_0000;
            end else begin
                n_red[r] = red_w[COORD_W-1:0];
            end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            diff = (COORD_W+1)'(signed'(r_s4_prev.red[a])) - (COORD_W+1)'(signed'(r_s4_red[a]));
            mag = diff[COORD_W] ? (~diff + 1'b1) : diff;
            rnd = (COORD_W+2)'(mag) + (COORD_W+2)'(32768);
            if (rnd[COORD_W+1:16] > (COORD_W-14)'(SHIFT_LIMIT)) begin
                cnt = SHIFT_LIMIT;
            end else begin
                cnt = rnd[16+SHIFT_W:16];
            end
            n_shift[a] = diff[COORD_W] ? -SHIFT_W'(cnt) : SHIFT_W'(cnt);
            n_pend[a] = r_s4_valid && r_s4_inr && r_s4_prev.seen && r_mask[a] && (cnt != '0);
        end
    end

    // Control part of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_pend  <= '0;
        end else if (en) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_pend  <= n_pend;
        end else if (i_ready) begin
            r_s5_pend <= r_s5_pend & ~low_bit;
        end
    end

    // Data part of the pipeline.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_inr       <= in_idx_w < MAX_IDX;
            r_s1_idx       <= i_particle_index;
            r_s1_frame     <= i_frame_number;
            r_s1_pos[0]    <= i_pos_x;
            r_s1_pos[1]    <= i_pos_y;
            r_s1_pos[2]    <= i_pos_z;
            r_s1_fwd       <= wr_act && (i_particle_index == r_s4_idx);
            r_s1_fwd_entry <= wr_entry;

            r_s2_inr   <= r_s1_inr;
            r_s2_idx   <= r_s1_idx;
            r_s2_frame <= r_s1_frame;
            r_s2_prev  <= snoop(s1_prev, r_s1_idx, wr_act, r_s4_idx, wr_entry);
            for (int r = 0; r < NUM_AXES; r++) begin
                r_s2_prod[r][0] <= signed'(r_cfg[2*r][63:32]) * r_s1_pos[0];
                r_s2_prod[r][1] <= signed'(r_cfg[2*r][31:0]) * r_s1_pos[1];
                r_s2_prod[r][2] <= signed'(r_cfg[2*r+1][63:32]) * r_s1_pos[2];
            end

            r_s3_inr   <= r_s2_inr;
            r_s3_idx   <= r_s2_idx;
            r_s3_frame <= r_s2_frame;
            r_s3_prev  <= snoop(r_s2_prev, r_s2_idx, wr_act, r_s4_idx, wr_entry);
            r_s3_sum   <= n_sum;

            r_s4_inr   <= r_s3_inr;
            r_s4_idx   <= r_s3_idx;
            r_s4_frame <= r_s3_frame;
            r_s4_prev  <= snoop(r_s3_prev, r_s3_idx, wr_act, r_s4_idx, wr_entry);
            r_s4_red   <= n_red;

            r_s5_idx   <= r_s4_idx;
            r_s5_frame <= r_s4_frame;
            r_s5_shift <= n_shift;
        end
    end

endmodule

// ===== bench/periodic_crossing_detector_unit_tb.sv =====
// Self-checking bench for periodic_crossing_detector_unit: particle samples in, crossing records out.
// Depends on pcd_pkg and the unit's RTL; it carries its own predictor of the unit.
module periodic_crossing_detector_unit_tb
    import pcd_pkg::*;
();

    localparam int N_PART = DEF_MAX_PARTICLES;
    localparam int STALL_LIMIT = 20000;  // covers the table clear after reset
    localparam int DRAIN_CYCLES = 12;
    localparam logic [31:0] ONE_Q130 = 32'h4000_0000;
    // An index past the last register.
    localparam logic [CFG_INDEX_W-1:0] CFG_BEYOND_LAST = 3'd7;

    typedef struct {
        logic [INDEX_W-1:0]        index;
        logic [FRAME_W-1:0]        frame;
        logic [1:0]                axis;
        logic signed [SHIFT_W-1:0] shift;
        logic                      last;
    } t_crossing;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [INDEX_W-1:0]        i_particle_index;
    logic [FRAME_W-1:0]        i_frame_number;
    logic signed [COORD_W-1:0] i_pos_x;
    logic signed [COORD_W-1:0] i_pos_y;
    logic signed [COORD_W-1:0] i_pos_z;
    logic                      o_valid;
    logic                      i_ready;
    logic [INDEX_W-1:0]        o_rec_index;
    logic [FRAME_W-1:0]        o_rec_frame;
    logic [1:0]                o_rec_axis;
    logic signed [SHIFT_W-1:0] o_rec_shift;
    logic                      o_rec_last;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    periodic_crossing_detector_unit DUT (.*);

    // Mirror of the configuration and the particle table.
    logic signed [31:0] coef[3][3];
    logic signed [31:0] trans[3];
    logic [2:0]         pbc_mask;
    logic signed [31:0] last_reduced[N_PART][3];
    bit                 particle_seen[N_PART];

    t_crossing pending_crossings[$];
    int  mismatches;
    int  quiet_cycles;
    bit  no_idle;
    int  frame_ctr;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Random gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One row of the affine map: rounded Q.46 sum to Q16.16, plus translation, saturated.
    function automatic logic signed [31:0] reduce_axis(input int r,
                                                       input logic signed [31:0] p[3]);
        logic signed [67:0] acc;
        acc = 68'sd536870912;
        for (int k = 0; k < 3; k++) acc = acc + coef[r][k] * p[k];
        acc = (acc >>> 30) + trans[r];
        if (acc > 68'sd2147483647) return 32'sh7FFF_FFFF;
        if (acc < -68'sd2147483648) return 32'sh8000_0000;
        return acc[31:0];
    endfunction

    // Old minus new, rounded half away from zero and saturated to the shift range.
    function automatic logic signed [15:0] wrap_shift(input logic signed [31:0] old_c,
                                                      input logic signed [31:0] new_c);
        logic signed [32:0] d;
        logic [33:0]        mag;
        logic [33:0]        n;
        d = old_c - new_c;
        mag = (d < 0) ? -d : d;
        n = (mag + 34'd32768) >> 16;
        if (n > 34'd32767) n = 34'd32767;
        return (d < 0) ? -n[15:0] : n[15:0];
    endfunction

    // Works out the crossings of one accepted sample and updates the table mirror.
    task automatic predict_crossings(input logic [INDEX_W-1:0] idx,
                                     input logic [FRAME_W-1:0] frame,
                                     input logic signed [31:0] p[3]);
        logic signed [31:0] red[3];
        t_crossing          recs[$];
        t_crossing          c;
        logic signed [15:0] s;
        for (int r = 0; r < 3; r++) red[r] = reduce_axis(r, p);
        if (particle_seen[idx]) begin
            for (int a = 0; a < 3; a++) begin
                s = wrap_shift(last_reduced[idx][a], red[a]);
                if (pbc_mask[a] && s != 0) begin
                    c.index = idx;
                    c.frame = frame;
                    c.axis = a[1:0];
                    c.shift = s;
                    c.last = 1'b0;
                    recs = {recs, c};
                end
            end
            if (recs.size() > 0) recs[recs.size()-1].last = 1'b1;
            foreach (recs[i]) pending_crossings = {pending_crossings, recs[i]};
        end
        for (int r = 0; r < 3; r++) last_reduced[idx][r] = red[r];
        particle_seen[idx] = 1'b1;
    endtask

    // Sends one sample request; returns after it has been accepted.
    task automatic send_sample(input logic [INDEX_W-1:0] idx,
                               input logic signed [31:0] x,
                               input logic signed [31:0] y,
                               input logic signed [31:0] z);
        int gap;
        logic signed [31:0] p[3];
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_particle_index = idx;
        i_frame_number = frame_ctr[FRAME_W-1:0];
        i_pos_x = x;
        i_pos_y = y;
        i_pos_z = z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        p[0] = x;
        p[1] = y;
        p[2] = z;
        predict_crossings(idx, frame_ctr[FRAME_W-1:0], p);
        frame_ctr = frame_ctr + $urandom_range(1, 3);
        @(negedge i_clk);
    endtask

    // Drops the sample valid and waits for every expected record plus the pipeline tail.
    task automatic drain();
        i_valid = 1'b0;
        while (pending_crossings.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes one register while the unit is idle and mirrors the write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        int r;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        r = idx / 2;
        if (idx < CFG_PERIODIC_MASK) begin
            if (idx[0] == 1'b0) begin
                coef[r][0] = data[63:32];
                coef[r][1] = data[31:0];
            end else begin
                coef[r][2] = data[63:32];
                trans[r] = data[31:0];
            end
        end else if (idx == CFG_PERIODIC_MASK) begin
            pbc_mask = data[2:0];
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Loads a full matrix: diag on the diagonal, off elsewhere, and translations t.
    task automatic load_matrix(input logic [31:0] diag, input logic [31:0] off,
                               input logic [31:0] t);
        write_reg(CFG_RECIP_XX_XY, {diag, off});
        write_reg(CFG_RECIP_XZ_TX, {off, t});
        write_reg(CFG_RECIP_YX_YY, {off, diag});
        write_reg(CFG_RECIP_YZ_TY, {off, t});
        write_reg(CFG_RECIP_ZX_ZY, {off, off});
        write_reg(CFG_RECIP_ZZ_TZ, {diag, t});
    endtask

    // A position near the box: a few cells either way with a random fraction.
    function automatic logic signed [31:0] near_pos();
        return $signed($urandom_range(0, 458752)) - 32'sd229376;
    endfunction

    // Identity map: first sample, repeat at full rate, half-way rounding in both signs.
    task automatic test_rounding();
        no_idle = 1'b1;
        load_matrix(ONE_Q130, 32'h0, 32'h0);
        write_reg(CFG_PERIODIC_MASK, 64'h7);
        send_sample(12'd0, 32'sh0, 32'sh0, 32'sh0);           // first: no records
        send_sample(12'd0, 32'sh0, 32'sh0, 32'sh0);           // zero shift everywhere
        send_sample(12'd0, -32'sh8000, 32'sh7FFF, 32'sh8000); // half rounds away from zero
        send_sample(12'd0, 32'sh0, 32'sh0, 32'sh0);
        send_sample(12'd0, 32'sh18000, -32'sh18000, 32'sh10000);
        send_sample(12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
        send_sample(12'd4095, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1); // saturated shift
        send_sample(12'd4095, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1);
        no_idle = 1'b0;
        drain();
    endtask

    // Coefficient and translation extremes, with saturation of the reduced coordinate.
    task automatic test_extremes();
        load_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(12'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_sample(12'd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_sample(12'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
        drain();
        load_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(12'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(12'd1, 32'sh1234_5678, -32'sh0765_4321, 32'sh7FFF_FFFF);
        drain();
        write_reg(CFG_BEYOND_LAST, 64'hFFFF_FFFF_FFFF_FFFF);  // beyond the list: ignored
        send_sample(12'd1, 32'sh0, 32'sh0, 32'sh0);
        drain();
    endtask

    // Mask settings 0, 1, 2, 4 and 5 with the identity matrix, particles hopping across cells.
    task automatic test_mask_settings();
        logic [2:0] masks[5] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
        load_matrix(ONE_Q130, 32'h0, 32'h0001_0000);
        foreach (masks[m]) begin
            write_reg(CFG_PERIODIC_MASK, {61'h0, masks[m]});
            repeat (3) send_sample(12'd2, near_pos(), near_pos(), near_pos());
            drain();
        end
        write_reg(CFG_PERIODIC_MASK, 64'h7);
    endtask

    // Random trajectories of a small particle pool under several random matrices.
    task automatic test_random_trajectories(input int n_items);
        logic [31:0] t;
        for (int phase = 0; phase < 4; phase++) begin
            t = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 131072);
            load_matrix(ONE_Q130 + $urandom_range(0, 4194304) - 2097152,
                        $urandom_range(0, 2097152) - 1048576, t);
            write_reg(CFG_PERIODIC_MASK, phase == 3 ? 64'h3 : 64'h7);
            for (int i = 0; i < n_items / 4; i++) begin
                if ($urandom_range(0, 9) < 8)
                    send_sample(INDEX_W'($urandom_range(0, 7)),
                                near_pos(), near_pos(), near_pos());
                else
                    send_sample(INDEX_W'($urandom()), $urandom(), $urandom(), $urandom());
            end
            drain();
        end
    endtask

    // Fully random matrix and samples: every bit of every field toggles.
    task automatic test_random_noise(input int n_items);
        write_reg(CFG_RECIP_XX_XY, {$urandom(), $urandom()});
        write_reg(CFG_RECIP_XZ_TX, {$urandom(), $urandom()});
        write_reg(CFG_RECIP_YX_YY, {$urandom(), $urandom()});
        write_reg(CFG_RECIP_YZ_TY, {$urandom(), $urandom()});
        write_reg(CFG_RECIP_ZX_ZY, {$urandom(), $urandom()});
        write_reg(CFG_RECIP_ZZ_TZ, {$urandom(), $urandom()});
        write_reg(CFG_PERIODIC_MASK, {$urandom(), $urandom()});
        for (int i = 0; i < n_items; i++)
            send_sample(INDEX_W'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 15)),
                        $urandom(), $urandom(), $urandom());
        drain();
    endtask

    // Record receiver: random stalls on i_ready, driven at the falling edge.
    initial begin
        int hold;
        i_ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                hold = $urandom_range(0, 99);
                if (no_idle || hold < 70) begin
                    i_ready = 1'b1;
                    hold = $urandom_range(1, 20);
                end else begin
                    i_ready = 1'b0;
                    hold = (hold < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    // Record checker and watchdog, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_crossings.size() == 0) begin
                report($sformatf("unexpected record index %0d axis %0d",
                                 o_rec_index, o_rec_axis));
            end else begin
                want = pending_crossings.pop_front();
                if (o_rec_index !== want.index)
                    report($sformatf("rec_index %0d, want %0d", o_rec_index, want.index));
                if (o_rec_frame !== want.frame)
                    report($sformatf("rec_frame %0d, want %0d", o_rec_frame, want.frame));
                if (o_rec_axis !== want.axis)
                    report($sformatf("rec_axis %0d, want %0d", o_rec_axis, want.axis));
                if (o_rec_shift !== want.shift)
                    report($sformatf("rec_shift %0d, want %0d", o_rec_shift, want.shift));
                if (o_rec_last !== want.last)
                    report($sformatf("rec_last %0b, want %0b", o_rec_last, want.last));
            end
        end
        if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        frame_ctr = 1048570;  // the frame number wraps early in the run
        for (int r = 0; r < 3; r++) begin
            trans[r] = '0;
            for (int k = 0; k < 3; k++) coef[r][k] = '0;
        end
        pbc_mask = 3'd7;
        for (int i = 0; i < N_PART; i++) particle_seen[i] = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_particle_index = '0;
        i_frame_number = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_rounding();
        test_extremes();
        test_mask_settings();
        test_random_trajectories(172);
        test_random_noise(60);

        if (mismatches == 0 && pending_crossings.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending_crossings.size() != 0)
                report($sformatf("%0d records never arrived", pending_crossings.size()));
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pcd_pkg.sv
sv/pcd_mem.sv
sv/periodic_crossing_detector_unit.sv
bench/periodic_crossing_detector_unit_tb.sv
